@@ rtl/cmrs_pkg.sv @@
// Package for the cluster statistics block: constants, codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package cmrs_pkg;

  localparam int MAX_CLUSTERS_DEF = 256;
  localparam int MAX_FEATURES_DEF = 8;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int NUM_VALUE_PORTS  = 8;
  localparam int VAL_W            = 32;
  localparam int SUM_W            = 48;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 9;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_QCL  = 2'd1;
  localparam logic [1:0] ACT_QSUM = 2'd2;
  localparam logic [1:0] ACT_CLR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OOR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NF = 1'b1;

  localparam logic [1:0] DIV_CEN = 2'd0;
  localparam logic [1:0] DIV_AVM = 2'd1;
  localparam logic [1:0] DIV_AVS = 2'd2;

  localparam logic [1:0] OUT_ERR = 2'd0;
  localparam logic [1:0] OUT_CLU = 2'd1;
  localparam logic [1:0] OUT_SUM = 2'd2;

  typedef struct packed {
    logic       cap;
    logic       clr_rst;
    logic       clr_wr;
    logic       cnt_ld;
    logic       cnt_wr;
    logic       add_wr;
    logic       j_inc;
    logic       i_clr;
    logic       i_inc;
    logic       acc_clr;
    logic       acc_add;
    logic       div_start;
    logic [1:0] div_op;
    logic       out_load;
    logic [1:0] out_kind;
  } cmrs_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       oor;
    logic       cnt_zero;
    logic       cnt_sat;
    logic       lane_last;
    logic       j_last;
    logic       i_last;
    logic       div_done;
    logic       clr_last;
  } cmrs_sts_t;

endpackage
`default_nettype wire

@@ rtl/cmrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cmrs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                                rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/cmrs_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module cmrs_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r, quo_r[NW-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(sh - {1'b0, den_r}) : sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

@@ rtl/cmrs_ctrl.sv @@
// Controller state machine: sequences adds, queries, clears and the
// post-reset sweep. Depends on cmrs_pkg.
`default_nettype none
module cmrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire cmrs_pkg::cmrs_sts_t sts,
  output cmrs_pkg::cmrs_cmd_t      cmd
);
  import cmrs_pkg::*;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_CHK  = 5'd3;
  localparam logic [4:0] S_ADDW = 5'd4;
  localparam logic [4:0] S_ADDG = 5'd5;
  localparam logic [4:0] S_QRD  = 5'd6;
  localparam logic [4:0] S_QDIV = 5'd7;
  localparam logic [4:0] S_QLD  = 5'd8;
  localparam logic [4:0] S_QOUT = 5'd9;
  localparam logic [4:0] S_QGAP = 5'd10;
  localparam logic [4:0] S_ELD  = 5'd11;
  localparam logic [4:0] S_EOUT = 5'd12;
  localparam logic [4:0] S_SJ   = 5'd13;
  localparam logic [4:0] S_SGAP = 5'd14;
  localparam logic [4:0] S_SI   = 5'd15;
  localparam logic [4:0] S_SDIV = 5'd16;
  localparam logic [4:0] S_SACC = 5'd17;
  localparam logic [4:0] S_SAVG = 5'd18;
  localparam logic [4:0] S_SAD1 = 5'd19;
  localparam logic [4:0] S_SAD2 = 5'd20;
  localparam logic [4:0] S_SLD  = 5'd21;
  localparam logic [4:0] S_SOUT = 5'd22;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          ACT_ADD, ACT_QCL: state_nxt = S_CHK;
          ACT_QSUM:         state_nxt = S_SJ;
          default: begin
            cmd.clr_rst = 1'b1;
            state_nxt   = S_CLR;
          end
        endcase
      end
      S_CHK: begin
        cmd.cnt_ld = 1'b1;
        if (sts.act == ACT_ADD) begin
          if (sts.oor || sts.cnt_sat) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_wr = 1'b1;
            state_nxt  = S_ADDW;
          end
        end else if (sts.oor || sts.cnt_zero) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_ERR;
          state_nxt    = S_EOUT;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_ADDW: begin
        cmd.add_wr = 1'b1;
        if (sts.lane_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_ADDG;
        end
      end
      S_ADDG: state_nxt = S_ADDW;
      S_QRD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_CEN;
        state_nxt     = S_QDIV;
      end
      S_QDIV: begin
        if (sts.div_done) state_nxt = S_QLD;
      end
      S_QLD: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OUT_CLU;
        state_nxt    = S_QOUT;
      end
      S_QOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.j_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_QGAP;
          end
        end
      end
      S_QGAP: state_nxt = S_QRD;
      S_ELD: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OUT_ERR;
        state_nxt    = S_EOUT;
      end
      S_EOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.j_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_ELD;
          end
        end
      end
      S_SJ: begin
        cmd.i_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_SGAP;
      end
      S_SGAP: state_nxt = S_SI;
      S_SI: begin
        if (sts.cnt_zero) begin
          if (sts.i_last) begin
            state_nxt = S_SAVG;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_SGAP;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_CEN;
          state_nxt     = S_SDIV;
        end
      end
      S_SDIV: begin
        if (sts.div_done) state_nxt = S_SACC;
      end
      S_SACC: begin
        cmd.acc_add = 1'b1;
        if (sts.i_last) begin
          state_nxt = S_SAVG;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_SGAP;
        end
      end
      S_SAVG: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_AVM;
        state_nxt     = S_SAD1;
      end
      S_SAD1: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_AVS;
          state_nxt     = S_SAD2;
        end
      end
      S_SAD2: begin
        if (sts.div_done) state_nxt = S_SLD;
      end
      S_SLD: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OUT_SUM;
        state_nxt    = S_SOUT;
      end
      S_SOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.j_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_SJ;
          end
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/cmrs_dp.sv @@
// Datapath: config registers, statistic memories, add arithmetic, shared
// divider, accumulators and result register. Depends on cmrs_pkg,
// cmrs_ram and cmrs_div.
`default_nettype none
module cmrs_dp #(
  parameter int MAX_CLUSTERS = cmrs_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_FEATURES = cmrs_pkg::MAX_FEATURES_DEF,
  parameter int COUNT_BITS   = cmrs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [cmrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cmrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic [1:0]                          in_action,
  input  wire logic [7:0]                          in_cluster,
  input  wire logic signed [cmrs_pkg::VAL_W-1:0]   in_value [MAX_FEATURES],
  input  wire cmrs_pkg::cmrs_cmd_t                 cmd,
  output cmrs_pkg::cmrs_sts_t                      sts,
  output logic [2:0]                               out_feature,
  output logic signed [cmrs_pkg::VAL_W-1:0]        out_mean,
  output logic [cmrs_pkg::VAL_W-1:0]               out_spread,
  output logic [15:0]                              out_count,
  output logic [1:0]                               out_status,
  output logic                                     out_last
);
  import cmrs_pkg::*;

  localparam int CAW  = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
  localparam int FAW  = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int CLW  = $clog2(MAX_CLUSTERS + 1);
  localparam int DW   = COUNT_BITS > CLW ? COUNT_BITS : CLW;
  localparam int ACCW = VAL_W + CAW + 1;
  localparam int NW   = SUM_W + 1;

  logic [CFG_DATA_W-1:0] nc_r;
  logic [3:0]            nf_r;
  logic [CLW-1:0]        nc_eff;
  logic [3:0]            nf_eff;

  logic [1:0]              act_r;
  logic [7:0]              k_r;
  logic signed [VAL_W-1:0] val_r [MAX_FEATURES];
  logic [FAW-1:0]          j_r;
  logic [CAW-1:0]          i_r;
  logic [CAW-1:0]          clr_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic [VAL_W-1:0]        spr_r;
  logic signed [VAL_W-1:0] cen_r;
  logic signed [ACCW-1:0]  accm_r;
  logic [ACCW-1:0]         accs_r;
  logic [1:0]              op_r;
  logic                    neg_r;

  logic [CAW-1:0]          cl_a;
  logic [CAW+FAW-1:0]      fr_a, fw_a;
  logic [COUNT_BITS-1:0]   cnt_rd;
  logic signed [SUM_W-1:0] sum_rd;
  logic signed [VAL_W-1:0] min_rd, max_rd;
  logic signed [VAL_W-1:0] cur_v;
  logic signed [SUM_W-1:0] sum_b, sum_w;
  logic signed [SUM_W:0]   s_ext;
  logic signed [VAL_W-1:0] min_w, max_w;
  logic                    cnt_we;
  logic [CAW-1:0]          cnt_wa;
  logic [COUNT_BITS-1:0]   cnt_wd;

  logic signed [NW-1:0]    num_s;
  logic [NW-1:0]           num_m;
  logic [DW-1:0]           den;
  logic                    div_done;
  logic [SUM_W-1:0]        quo;
  logic signed [NW-1:0]    qs;
  logic signed [VAL_W-1:0] qclamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= CFG_DATA_W'(1);
      nf_r <= 4'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NC) nc_r <= cfg_wdata;
      if (cfg_index == CFG_NF) nf_r <= cfg_wdata[3:0];
    end
  end

  always_comb begin
    if (nc_r == '0) nc_eff = CLW'(1);
    else if (32'(nc_r) > 32'(MAX_CLUSTERS)) nc_eff = CLW'(MAX_CLUSTERS);
    else nc_eff = CLW'(nc_r);
    if (nf_r == '0) nf_eff = 4'd1;
    else if (32'(nf_r) > 32'(MAX_FEATURES)) nf_eff = 4'(MAX_FEATURES);
    else nf_eff = nf_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_action;
      k_r   <= in_cluster;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r   <= '0;
      i_r   <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.cap) j_r <= '0;
      else if (cmd.j_inc) j_r <= j_r + 1'b1;
      if (cmd.cap || cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + 1'b1;
      if (cmd.clr_rst) clr_r <= '0;
      else if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
    end
  end

  assign cl_a = (act_r == ACT_QSUM) ? i_r : CAW'(k_r);
  assign fr_a = {cl_a, j_r};
  assign fw_a = {CAW'(k_r), j_r};

  // count store
  assign cnt_we = cmd.clr_wr | cmd.cnt_wr;
  assign cnt_wa = cmd.clr_wr ? clr_r : CAW'(k_r);
  assign cnt_wd = cmd.clr_wr ? '0 : cnt_rd + 1'b1;

  cmrs_ram #(.W(COUNT_BITS), .DEPTH(1 << CAW)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cl_a), .rdata(cnt_rd)
  );

  // add: a zero count means the lane holds nothing yet
  assign cur_v = val_r[j_r];
  assign sum_b = (cnt_r == '0) ? '0 : sum_rd;
  assign s_ext = {sum_b[SUM_W-1], sum_b} + (SUM_W+1)'(cur_v);
  assign sum_w = (s_ext[SUM_W] != s_ext[SUM_W-1]) ?
                 {s_ext[SUM_W], {(SUM_W-1){~s_ext[SUM_W]}}} : s_ext[SUM_W-1:0];
  assign min_w = ((cnt_r == '0) || (cur_v < min_rd)) ? cur_v : min_rd;
  assign max_w = ((cnt_r == '0) || (cur_v > max_rd)) ? cur_v : max_rd;

  cmrs_ram #(.W(SUM_W), .DEPTH(1 << (CAW + FAW))) u_sum_ram (
    .clk(clk), .we(cmd.add_wr), .waddr(fw_a), .wdata(sum_w),
    .raddr(fr_a), .rdata(sum_rd)
  );
  cmrs_ram #(.W(VAL_W), .DEPTH(1 << (CAW + FAW))) u_min_ram (
    .clk(clk), .we(cmd.add_wr), .waddr(fw_a), .wdata(min_w),
    .raddr(fr_a), .rdata(min_rd)
  );
  cmrs_ram #(.W(VAL_W), .DEPTH(1 << (CAW + FAW))) u_max_ram (
    .clk(clk), .we(cmd.add_wr), .waddr(fw_a), .wdata(max_w),
    .raddr(fr_a), .rdata(max_rd)
  );

  // divider operands: magnitude in, sign applied afterwards
  always_comb begin
    case (cmd.div_op)
      DIV_CEN: begin
        num_s = NW'(sum_rd);
        den   = DW'(cnt_rd);
      end
      DIV_AVM: begin
        num_s = NW'(accm_r);
        den   = DW'(nc_eff);
      end
      default: begin
        num_s = $signed(NW'(accs_r));
        den   = DW'(nc_eff);
      end
    endcase
    num_m = num_s[NW-1] ? -num_s : num_s;
  end

  cmrs_div #(.NW(SUM_W), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num_m[SUM_W-1:0]),
    .den(den), .done(div_done), .quo(quo)
  );

  assign qs = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    if (qs > NW'(64'sd2147483647)) qclamp = 32'sh7FFFFFFF;
    else if (qs < -NW'(64'sd2147483648)) qclamp = 32'sh80000000;
    else qclamp = qs[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_ld) cnt_r <= cnt_rd;
    if (cmd.div_start) begin
      op_r  <= cmd.div_op;
      neg_r <= num_s[NW-1];
      if (cmd.div_op == DIV_CEN) spr_r <= max_rd - min_rd;
    end
    if (div_done) begin
      case (op_r)
        DIV_CEN: cen_r      <= qclamp;
        DIV_AVM: out_mean   <= qs[VAL_W-1:0];
        default: out_spread <= quo[VAL_W-1:0];
      endcase
    end
    if (cmd.acc_clr) begin
      accm_r <= '0;
      accs_r <= '0;
    end else if (cmd.acc_add) begin
      accm_r <= accm_r + ACCW'(cen_r);
      accs_r <= accs_r + ACCW'(spr_r);
    end
    if (cmd.out_load) begin
      out_feature <= 3'(j_r);
      out_last    <= sts.j_last;
      case (cmd.out_kind)
        OUT_ERR: begin
          out_mean   <= '0;
          out_spread <= '0;
          out_count  <= '0;
          out_status <= sts.oor ? ST_OOR : ST_EMPTY;
        end
        OUT_CLU: begin
          out_mean   <= cen_r;
          out_spread <= spr_r;
          out_count  <= (32'(cnt_r) > 32'd65535) ? 16'hFFFF : 16'(cnt_r);
          out_status <= ST_OK;
        end
        default: begin
          out_count  <= '0;
          out_status <= ST_OK;
        end
      endcase
    end
  end

  assign sts.act       = act_r;
  assign sts.oor       = 32'(k_r) >= 32'(nc_eff);
  assign sts.cnt_zero  = cnt_rd == '0;
  assign sts.cnt_sat   = &cnt_rd;
  assign sts.lane_last = 32'(j_r) + 32'd1 == 32'(MAX_FEATURES);
  assign sts.j_last    = 32'(j_r) + 32'd1 == 32'(nf_eff);
  assign sts.i_last    = 32'(i_r) + 32'd1 == 32'(nc_eff);
  assign sts.div_done  = div_done;
  assign sts.clr_last  = 32'(clr_r) == 32'(MAX_CLUSTERS - 1);
endmodule
`default_nettype wire

@@ rtl/cluster_mean_and_range_stats.sv @@
// Per-cluster mean and range statistics, one item at a time. After reset, and
// after every clear item, the block sweeps the point counts of all clusters up
// to MAX_CLUSTERS and takes no item meanwhile. In an add, every feature lane
// gets a read and a read-modify-write of the sum, minimum and maximum
// memories. A cluster query runs the 48-step serial divider once per reported
// feature to form its centroid; an empty or out-of-range cluster answers with
// a flagged result per feature and no division. A summary query walks all
// clusters in use for every feature, with one division per non-empty cluster
// plus two averaging divisions per feature.
// Depends on cmrs_pkg, cmrs_ctrl and cmrs_dp.
`default_nettype none
module cluster_mean_and_range_stats #(
  parameter int MAX_CLUSTERS = cmrs_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_FEATURES = cmrs_pkg::MAX_FEATURES_DEF,
  parameter int COUNT_BITS   = cmrs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cmrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cmrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic [7:0]                        in_cluster,
  input  wire logic signed [31:0]                in_value_0,
  input  wire logic signed [31:0]                in_value_1,
  input  wire logic signed [31:0]                in_value_2,
  input  wire logic signed [31:0]                in_value_3,
  input  wire logic signed [31:0]                in_value_4,
  input  wire logic signed [31:0]                in_value_5,
  input  wire logic signed [31:0]                in_value_6,
  input  wire logic signed [31:0]                in_value_7,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_feature,
  output logic signed [31:0]                     out_mean,
  output logic [31:0]                            out_spread,
  output logic [15:0]                            out_count,
  output logic [1:0]                             out_status,
  output logic                                   out_last
);
  import cmrs_pkg::*;

  logic signed [VAL_W-1:0] val_all [NUM_VALUE_PORTS];
  logic signed [VAL_W-1:0] lanes   [MAX_FEATURES];
  cmrs_cmd_t               cmd;
  cmrs_sts_t               sts;

  assign val_all[0] = in_value_0;
  assign val_all[1] = in_value_1;
  assign val_all[2] = in_value_2;
  assign val_all[3] = in_value_3;
  assign val_all[4] = in_value_4;
  assign val_all[5] = in_value_5;
  assign val_all[6] = in_value_6;
  assign val_all[7] = in_value_7;

  for (genvar g = 0; g < MAX_FEATURES; g++) begin : g_lane
    assign lanes[g] = val_all[g];
  end

  cmrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  cmrs_dp #(
    .MAX_CLUSTERS(MAX_CLUSTERS), .MAX_FEATURES(MAX_FEATURES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_action(in_action), .in_cluster(in_cluster),
    .in_value(lanes), .cmd(cmd), .sts(sts), .out_feature(out_feature),
    .out_mean(out_mean), .out_spread(out_spread), .out_count(out_count),
    .out_status(out_status), .out_last(out_last)
  );
endmodule
`default_nettype wire

@@ rtl/cmrs_chk.sv @@
// Port-level checker for the cluster statistics block and its bind.
// Depends on cmrs_pkg and cluster_mean_and_range_stats.
`default_nettype none
module cmrs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_feature,
  input wire logic [31:0] out_mean,
  input wire logic [31:0] out_spread,
  input wire logic [15:0] out_count,
  input wire logic [1:0]  out_status,
  input wire logic        out_last
);
  import cmrs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_feature) &&
      $stable(out_mean) && $stable(out_spread) && $stable(out_status) &&
      $stable(out_last))
    else $error("result beat changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken while a result is pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_OOR) |->
      out_mean == '0 && out_spread == '0 && out_count == '0)
    else $error("flagged result carries data");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");
endmodule

bind cluster_mean_and_range_stats cmrs_chk u_cmrs_chk (.*);
`default_nettype wire
